// File: rtl/core/sem_pkg.sv
package sem_pkg;

  localparam int FW_W = 11;
  localparam int FH_W = 13;
  localparam int IN_ROW_W = 13;
  localparam int OUT_ROW_W = 12;
  localparam int CH_W = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W = CH_W * NUM_CH;
  localparam int GRAD_W = 11;
  localparam int SQ_W = 21;
  localparam int ROOT_STEPS = 8;
  localparam int STEP_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH = 2;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;
  localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [IN_ROW_W-1:0] IN_ROW_MAX = 13'h1FFF;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic             func;
    logic [CH_W-1:0]  in_blue;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_red;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]  edge_blue;
    logic [CH_W-1:0]  edge_green;
    logic [CH_W-1:0]  edge_red;
    logic             frame_last;
  } out_t;

  // Pixel packing: blue in the low byte, red in the high byte.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             emit;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
  } entry_t;

  typedef struct packed {
    logic pos_zero;
  } fstat_t;

  typedef struct packed {
    logic idle;
  } bstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAD,
    ST_SQ,
    ST_ROOT,
    ST_OUT
  } st_e;

endpackage

// File: rtl/core/sobel_edge_magnitude_rgb.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  in_data_i   (func, in_blue, in_green, in_red)
// out      output     out_valid_o/out_ready_i out_data_o (edge_blue/green/red, frame_last)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item that yields a result passes through the back end in turn: queue pop with line
// buffer read, gradient, squaring, eight root steps of one bit each, and the output load.
// An item without a result takes only the pop and gradient. A two-entry queue lets input beats arrive
// while the back end works; an output beat still waiting when the next result is ready
// holds the back end at its load step, and input stalls once the queue is full.
// Reset is asynchronous and clears control state; line buffers keep their contents.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sem_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sem_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int QW = $bits(sem_pkg::entry_t) + CW;

  logic            q_push, q_pop, q_full, q_empty;
  sem_pkg::entry_t f_entry, b_entry;
  logic [CW-1:0]   f_addr, b_addr;
  sem_pkg::fstat_t fstat;
  sem_pkg::bstat_t bstat;

  sem_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .WW        (WW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (f_entry),
    .q_addr_o    (f_addr),
    .stat_o      (fstat)
  );

  sem_queue #(
    .DW (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_addr, f_entry}),
    .pop_i   (q_pop),
    .rdata_o ({b_addr, b_entry}),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sem_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (b_entry),
    .q_addr_i    (b_addr),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (bstat)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o &&
     ((cfg_index_i == sem_pkg::REG_FRAME_WIDTH) ||
      (cfg_index_i == sem_pkg::REG_FRAME_HEIGHT))) |=> fstat.pos_zero)
    else $error("register write did not restart the frame position");

  a_back_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bstat.idle && !q_empty) |=> !bstat.idle)
    else $error("back end idle with a queued beat");
`endif

endmodule

// File: rtl/core/sem_queue.sv
module sem_queue #(
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PW = $clog2(sem_pkg::Q_DEPTH);
  localparam int NW = $clog2(sem_pkg::Q_DEPTH + 1);

  logic [DW-1:0] slot_q [sem_pkg::Q_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == NW'(sem_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(sem_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(sem_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/sem_front.sv
module sem_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW = 10,
  parameter int WW = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  sem_pkg::in_t                        in_data_i,
  output logic                                in_ready_o,
  input  logic                                cfg_valid_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                cfg_ready_o,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output sem_pkg::entry_t                     q_entry_o,
  output logic [CW-1:0]                       q_addr_o,
  output sem_pkg::fstat_t                     stat_o
);

  localparam int CMPW = (WW > sem_pkg::FW_W) ? WW : sem_pkg::FW_W;

  logic [sem_pkg::FW_W-1:0]      fw_q, fw_d;
  logic [sem_pkg::FH_W-1:0]      fh_q, fh_d;
  logic [CW-1:0]                 in_col_q, in_col_d;
  logic [sem_pkg::IN_ROW_W-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]                 out_col_q, out_col_d;
  logic [sem_pkg::OUT_ROW_W-1:0] out_row_q, out_row_d;

  logic [CMPW-1:0]               fw_ext, w_ext;
  logic [WW-1:0]                 w;
  logic [CW-1:0]                 wm1;
  logic [sem_pkg::FH_W-1:0]      h, hm1_full;
  logic [sem_pkg::OUT_ROW_W-1:0] hm1;
  logic                          emit, last, cfg_hit;

  // Out-of-range sizes are clamped into the supported range.
  always_comb begin
    fw_ext = CMPW'(fw_q);
    if (fw_ext == '0) begin
      w_ext = CMPW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_ext = CMPW'(MAX_WIDTH);
    end else begin
      w_ext = fw_ext;
    end
    w   = WW'(w_ext);
    wm1 = CW'(w - WW'(1));

    if (fh_q == '0) begin
      h = sem_pkg::FH_W'(1);
    end else if (fh_q > sem_pkg::HEIGHT_LIMIT) begin
      h = sem_pkg::HEIGHT_LIMIT;
    end else begin
      h = fh_q;
    end
    hm1_full = h - sem_pkg::FH_W'(1);
    hm1      = hm1_full[sem_pkg::OUT_ROW_W-1:0];
  end

  // A result appears once the window's bottom-right sample has arrived.
  assign emit = (in_row_q >= sem_pkg::IN_ROW_W'(2)) ||
                ((in_row_q == sem_pkg::IN_ROW_W'(1)) && (in_col_q != '0));
  assign last = (out_row_q == hm1) && (out_col_q == wm1);

  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && ((cfg_index_i == sem_pkg::REG_FRAME_WIDTH) ||
                                       (cfg_index_i == sem_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    q_entry_o.pixel    = (in_data_i.func == sem_pkg::FUNC_DRAIN) ? '0 :
                         {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
    q_entry_o.emit     = emit;
    q_entry_o.last     = emit && last;
    q_entry_o.top_ok   = (out_row_q != '0);
    q_entry_o.bot_ok   = (out_row_q != hm1);
    q_entry_o.left_ok  = (out_col_q != '0);
    q_entry_o.right_ok = (out_col_q != wm1);
    q_addr_o           = in_col_q;
  end

  always_comb begin
    fw_d      = fw_q;
    fh_d      = fh_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_hit) begin
      if (cfg_index_i == sem_pkg::REG_FRAME_WIDTH) begin
        fw_d = cfg_data_i[sem_pkg::FW_W-1:0];
      end else begin
        fh_d = cfg_data_i[sem_pkg::FH_W-1:0];
      end
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (q_push_o) begin
      if (emit && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (emit) begin
          if (out_col_q == wm1) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
        if (in_col_q == wm1) begin
          in_col_d = '0;
          if (in_row_q != sem_pkg::IN_ROW_MAX) begin
            in_row_d = in_row_q + 1'b1;
          end
        end else begin
          in_col_d = in_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= sem_pkg::FW_RESET;
      fh_q      <= sem_pkg::FH_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      fw_q      <= fw_d;
      fh_q      <= fh_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign stat_o.pos_zero = (in_col_q == '0) && (in_row_q == '0) &&
                           (out_col_q == '0) && (out_row_q == '0);

endmodule

// File: rtl/core/sem_back.sv
module sem_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  sem_pkg::entry_t q_entry_i,
  input  logic [CW-1:0]   q_addr_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sem_pkg::out_t   out_data_o,
  output sem_pkg::bstat_t stat_o
);

  localparam int PW = sem_pkg::PIX_W;
  localparam int CH = sem_pkg::CH_W;
  localparam int GW = sem_pkg::GRAD_W;
  localparam int SW = sem_pkg::SQ_W;

  sem_pkg::st_e state_q, state_d;

  // Two line buffers: the first delays by one row, the second by two.
  logic [PW-1:0] line_a [MAX_WIDTH];
  logic [PW-1:0] line_b [MAX_WIDTH];
  logic [PW-1:0] rd_a_q, rd_b_q;

  sem_pkg::entry_t ent_q;
  logic [CW-1:0]   addr_q;
  logic [PW-1:0]   p1_q, p2_q, a1_q, a2_q, b1_q, b2_q;

  logic signed [GW-1:0] gx_q [sem_pkg::NUM_CH];
  logic signed [GW-1:0] gy_q [sem_pkg::NUM_CH];
  logic signed [GW-1:0] gx_d [sem_pkg::NUM_CH];
  logic signed [GW-1:0] gy_d [sem_pkg::NUM_CH];
  logic [SW-1:0]        s_q  [sem_pkg::NUM_CH];
  logic [CH-1:0]        n_q  [sem_pkg::NUM_CH];
  logic [CH-1:0]        n_d  [sem_pkg::NUM_CH];
  logic [sem_pkg::STEP_W-1:0] step_q;

  logic          out_valid_q;
  sem_pkg::out_t out_q;
  logic          load;

  // Window taps, masked to zero outside the image.
  logic [PW-1:0] tl, tm, tr, ml, mm, mr, bl, bm, br;

  always_comb begin
    tl = (ent_q.top_ok && ent_q.left_ok)  ? b2_q : '0;
    tm = ent_q.top_ok                     ? b1_q : '0;
    tr = (ent_q.top_ok && ent_q.right_ok) ? rd_b_q : '0;
    ml = ent_q.left_ok                    ? a2_q : '0;
    mm = a1_q;
    mr = ent_q.right_ok                   ? rd_a_q : '0;
    bl = (ent_q.bot_ok && ent_q.left_ok)  ? p2_q : '0;
    bm = ent_q.bot_ok                     ? p1_q : '0;
    br = (ent_q.bot_ok && ent_q.right_ok) ? ent_q.pixel : '0;
  end

  always_comb begin
    for (int c = 0; c < sem_pkg::NUM_CH; c++) begin
      gx_d[c] = (GW'(br[c*CH +: CH]) - GW'(bl[c*CH +: CH]))
              + ((GW'(mr[c*CH +: CH]) - GW'(ml[c*CH +: CH])) <<< 1)
              + (GW'(tr[c*CH +: CH]) - GW'(tl[c*CH +: CH]));
      gy_d[c] = (GW'(bl[c*CH +: CH]) + (GW'(bm[c*CH +: CH]) << 1) + GW'(br[c*CH +: CH]))
              - (GW'(tl[c*CH +: CH]) + (GW'(tm[c*CH +: CH]) << 1) + GW'(tr[c*CH +: CH]));
    end
  end

  // One bit of each root per cycle: keep the trial bit while t(t-1) < s.
  always_comb begin
    logic [CH-1:0]   t;
    logic [2*CH-1:0] prod;
    for (int c = 0; c < sem_pkg::NUM_CH; c++) begin
      t    = n_q[c] | (CH'(1) << step_q);
      prod = (2*CH)'(t) * (2*CH)'(t - CH'(1));
      n_d[c] = (SW'(prod) < s_q[c]) ? t : n_q[c];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::ST_IDLE: if (!q_empty_i) state_d = sem_pkg::ST_GRAD;
      sem_pkg::ST_GRAD: state_d = ent_q.emit ? sem_pkg::ST_SQ : sem_pkg::ST_IDLE;
      sem_pkg::ST_SQ:   state_d = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: if (step_q == '0) state_d = sem_pkg::ST_OUT;
      sem_pkg::ST_OUT:  if (load) state_d = sem_pkg::ST_IDLE;
      default:          state_d = sem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (state_q == sem_pkg::ST_IDLE) && !q_empty_i;
    load    = (state_q == sem_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
    stat_o.idle = (state_q == sem_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sem_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q  <= q_entry_i;
      addr_q <= q_addr_i;
      rd_a_q <= line_a[q_addr_i];
      rd_b_q <= line_b[q_addr_i];
    end
    if (state_q == sem_pkg::ST_GRAD) begin
      line_a[addr_q] <= ent_q.pixel;
      line_b[addr_q] <= rd_a_q;
      p1_q <= ent_q.pixel;
      p2_q <= p1_q;
      a1_q <= rd_a_q;
      a2_q <= a1_q;
      b1_q <= rd_b_q;
      b2_q <= b1_q;
      for (int c = 0; c < sem_pkg::NUM_CH; c++) begin
        gx_q[c] <= gx_d[c];
        gy_q[c] <= gy_d[c];
      end
    end
    if (state_q == sem_pkg::ST_SQ) begin
      for (int c = 0; c < sem_pkg::NUM_CH; c++) begin
        s_q[c] <= SW'(gx_q[c] * gx_q[c]) + SW'(gy_q[c] * gy_q[c]);
        n_q[c] <= '0;
      end
      step_q <= sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1);
    end
    if (state_q == sem_pkg::ST_ROOT) begin
      for (int c = 0; c < sem_pkg::NUM_CH; c++) begin
        n_q[c] <= n_d[c];
      end
      step_q <= step_q - 1'b1;
    end
    if (load) begin
      out_q.edge_blue  <= n_q[0];
      out_q.edge_green <= n_q[1];
      out_q.edge_red   <= n_q[2];
      out_q.frame_last <= ent_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
